// File: rtl/heading_hold_with_tack_timer_defines.svh
// Assertion macros for the heading hold block.
`ifndef HEADING_HOLD_WITH_TACK_TIMER_DEFINES_SVH
`define HEADING_HOLD_WITH_TACK_TIMER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, clocked on clk, off while in reset.
`define HHT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("heading hold assertion failed");
// Next-cycle implication.
`define HHT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("heading hold assertion failed");
`else
`define HHT_ASSERT_IMP(lbl, ante, cons)
`define HHT_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// File: rtl/hhtt_pkg.sv
// Types and constants for the heading hold with tack timer.
`timescale 1ns / 1ps
`default_nettype none

package hhtt_pkg;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_GAIN   = 2'd0,
    CFG_OFFSET = 2'd1,
    CFG_PERIOD = 2'd2,
    CFG_LIMIT  = 2'd3
  } cfg_idx_t;

  // reset values of the registers
  localparam logic [11:0] GAIN_RST   = 12'd256;
  localparam logic [13:0] OFFSET_RST = 14'd3000;
  localparam logic [15:0] PERIOD_RST = 16'd10000;
  localparam logic [6:0]  LIMIT_RST  = 7'd30;

  // head-to-wind window, hundredths of a degree (strict compares)
  localparam logic [15:0] HTW_HIGH = 16'd34500;
  localparam logic [15:0] HTW_LOW  = 16'd1500;

  // wrap thresholds and corrections, 19-bit signed
  localparam logic signed [18:0] HALF_TURN  = 19'sd18000;
  localparam logic signed [18:0] NEG_HALF   = -19'sd18000;
  localparam logic signed [18:0] NEG_3HALF  = -19'sd54000;
  localparam logic signed [18:0] NEG_5HALF  = -19'sd90000;
  localparam logic signed [18:0] FULL_TURN  = 19'sd36000;
  localparam logic signed [18:0] TWO_TURNS  = 19'sd72000;
  localparam logic signed [18:0] THREE_TURNS = 19'sd108000;

  // |rudder| = floor(prod / 25600) = floor((prod >> 8) / 100)
  // quotient of 128 or more always saturates (limit <= 127)
  localparam logic [18:0] SAT_QUOT = 19'd12800;
  // floor(x / 100) == (x * 5243) >> 19, exact for x < 12800
  localparam logic [12:0] RECIP_100 = 13'd5243;
  localparam int unsigned RECIP_SHIFT = 19;

endpackage

`default_nettype wire

// File: rtl/heading_hold_with_tack_timer.sv
// Heading hold controller with tack timer, three-stage pipeline.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake              Payload
// in_       in   in_tvalid/in_tready    in_tdata: target, measured, wind, time_ms
// out_      out  out_tvalid/out_tready  out_tdata: rudder, error, htw, side
// cfg_      in   cfg_valid/cfg_ready    cfg_index, cfg_data
//
// One request per clock when out_tready is high.
// Stages: tack timer + raw error sum / wrap + gain multiply / divide + clamp.
// The gain multiply and the reciprocal multiply each own a stage.
// A stalled output freezes the whole pipe; in_tready = !out_tvalid | out_tready.
// rst_n is synchronous: clears the tack state, valid bits and config to defaults.

module heading_hold_with_tack_timer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // [15:0] target_heading (s), [31:16] measured_heading, [47:32] wind_direction,
  // [79:48] time_ms
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [79:0] in_tdata,
  // [7:0] rudder_angle (s), [23:8] heading_error (s), [24] head_to_wind,
  // [25] tack_side, [31:26] zero
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,
  // config write: index 0 gain_q8, 1 tack_offset, 2 tack_period_ms, 3 rudder_limit
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  `include "heading_hold_with_tack_timer_defines.svh"

  // ---------------- configuration ----------------
  logic [11:0] gain_r;
  logic [13:0] offset_r;
  logic [15:0] period_r;
  logic [6:0]  limit_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r   <= hhtt_pkg::GAIN_RST;
      offset_r <= hhtt_pkg::OFFSET_RST;
      period_r <= hhtt_pkg::PERIOD_RST;
      limit_r  <= hhtt_pkg::LIMIT_RST;
    end else if (cfg_valid) begin
      unique case (hhtt_pkg::cfg_idx_t'(cfg_index))
        hhtt_pkg::CFG_GAIN:   gain_r   <= cfg_data[11:0];
        hhtt_pkg::CFG_OFFSET: offset_r <= cfg_data[13:0];
        hhtt_pkg::CFG_PERIOD: period_r <= cfg_data;
        hhtt_pkg::CFG_LIMIT:  limit_r  <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // ---------------- pipeline control ----------------
  logic en;           // whole pipe advances
  logic in_req;       // request accepted this cycle
  logic v1_r, v2_r, out_valid_r;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;
  assign in_req    = in_tvalid && en;

  // ---------------- stage 1: tack timer and raw error ----------------
  logic [15:0] tgt, meas, wind;
  logic [31:0] now;
  assign tgt  = in_tdata[15:0];
  assign meas = in_tdata[31:16];
  assign wind = in_tdata[47:32];
  assign now  = in_tdata[79:48];

  logic        running_r, running_nxt;
  logic [31:0] start_r, start_nxt;
  logic        side_r, side_nxt;

  logic        htw, adv, expired;
  logic [31:0] elapsed;
  logic signed [17:0] offs, sum_nxt;

  always_comb begin
    htw     = (wind > hhtt_pkg::HTW_HIGH) || (wind < hhtt_pkg::HTW_LOW);
    adv     = htw || running_r;
    // a fresh start has zero elapsed time
    elapsed = running_r ? (now - start_r) : 32'd0;
    expired = adv && (elapsed > {16'd0, period_r});

    running_nxt = adv && !expired;
    start_nxt   = (adv && !running_r) ? now : start_r;
    side_nxt    = side_r ^ expired;

    // offset sign follows the side after this sample's flip
    if (!adv)
      offs = 18'sd0;
    else if (side_nxt)
      offs = $signed({4'd0, offset_r});
    else
      offs = -$signed({4'd0, offset_r});

    sum_nxt = $signed({{2{tgt[15]}}, tgt}) - $signed({2'd0, meas}) + offs;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      start_r   <= 32'd0;
      side_r    <= 1'b0;
    end else if (in_req) begin
      running_r <= running_nxt;
      start_r   <= start_nxt;
      side_r    <= side_nxt;
    end
  end

  logic signed [17:0] sum_s1_r;
  logic               htw_s1_r, side_s1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sum_s1_r  <= sum_nxt;
      htw_s1_r  <= htw;
      side_s1_r <= side_nxt;
    end
  end

  // ---------------- stage 2: wrap, magnitude, gain multiply ----------------
  logic signed [18:0] sx, err_w;
  logic [14:0]        err_abs;
  logic [26:0]        prod_nxt;

  always_comb begin
    sx = {sum_s1_r[17], sum_s1_r};
    // sum spans about -114686..49150: at most three full turns up, one down
    priority if (sx < hhtt_pkg::NEG_5HALF)
      err_w = sx + hhtt_pkg::THREE_TURNS;
    else if (sx < hhtt_pkg::NEG_3HALF)
      err_w = sx + hhtt_pkg::TWO_TURNS;
    else if (sx < hhtt_pkg::NEG_HALF)
      err_w = sx + hhtt_pkg::FULL_TURN;
    else if (sx > hhtt_pkg::HALF_TURN)
      err_w = sx - hhtt_pkg::FULL_TURN;
    else
      err_w = sx;
    err_abs  = err_w[18] ? 15'(-err_w) : err_w[14:0];
    prod_nxt = 27'(gain_r) * 27'(err_abs);
  end

  logic [26:0] prod_r;
  logic [15:0] err_s2_r;
  logic        pos_s2_r, htw_s2_r, side_s2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r    <= prod_nxt;
      err_s2_r  <= err_w[15:0];
      pos_s2_r  <= !err_w[18] && (err_w != 19'sd0);
      htw_s2_r  <= htw_s1_r;
      side_s2_r <= side_s1_r;
    end
  end

  // ---------------- stage 3: divide by 25600, clamp, sign ----------------
  logic [18:0] quot_in;
  logic [26:0] recip_prod;
  logic [7:0]  quot, mag;
  logic [7:0]  lim8;
  logic [7:0]  rudder_nxt;

  always_comb begin
    quot_in    = prod_r[26:8];
    recip_prod = 27'(quot_in[13:0]) * 27'(hhtt_pkg::RECIP_100);
    quot       = recip_prod[hhtt_pkg::RECIP_SHIFT +: 8];
    lim8       = {1'b0, limit_r};
    if (quot_in >= hhtt_pkg::SAT_QUOT || quot > lim8)
      mag = lim8;
    else
      mag = quot;
    rudder_nxt = pos_s2_r ? 8'(-mag) : mag;
  end

  logic [7:0]  rudder_r;
  logic [15:0] err_r;
  logic        htw_r, side_out_r;

  always_ff @(posedge clk) begin
    if (en) begin
      rudder_r   <= rudder_nxt;
      err_r      <= err_s2_r;
      htw_r      <= htw_s2_r;
      side_out_r <= side_s2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= in_tvalid;
      v2_r        <= v1_r;
      out_valid_r <= v2_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, side_out_r, htw_r, err_r, rudder_r};

  // ---------------- assertions ----------------
  // a running tack keeps its start time
  `HHT_ASSERT_IMP(a_start_held, $past(running_r) && running_r, $stable(start_r))
  // the side only flips when a tack ends
  `HHT_ASSERT_IMP(a_flip_ends_tack, side_r != $past(side_r), !running_r)
  // delivered error is wrapped and rudder opposes it
  `HHT_ASSERT_IMP(a_err_wrapped, out_valid_r,
    ($signed(err_r) <= 16'sd18000) && ($signed(err_r) >= -16'sd18000))
  `HHT_ASSERT_IMP(a_rudder_sign, out_valid_r && ($signed(err_r) > 16'sd0),
    ($signed(rudder_r) <= 8'sd0))

endmodule

`default_nettype wire
